// File: hw/rtl/bmh_pkg.sv
package bmh_pkg;

    localparam int DEPTH     = 256;
    localparam int KEY_BITS  = 32;
    localparam int TAG_BITS  = 16;
    localparam int CFG_W     = 9;
    localparam int CAP_RESET = 256;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_BITS + TAG_BITS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT_CHK,
        S_POP_CHK,
        S_UP_RD,
        S_UP_CHK,
        S_DN_RD,
        S_DN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic b_min;
        logic child_lt;
        logic x_lt_a;
    } t_cmp;

endpackage

// File: hw/rtl/bmh_ram.sv
module bmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hw/rtl/bmh_cmp.sv
module bmh_cmp (
    input  logic [bmh_pkg::KEY_BITS-1:0] i_x_key,
    input  logic [bmh_pkg::KEY_BITS-1:0] i_a_key,
    input  logic [bmh_pkg::KEY_BITS-1:0] i_b_key,
    input  logic                         i_b_ok,
    output bmh_pkg::t_cmp                o_res
);

    import bmh_pkg::*;

    logic [KEY_BITS-1:0] w_min;
    logic                w_b_min;

    always_comb begin
        w_b_min        = i_b_ok && (i_b_key < i_a_key);
        w_min          = w_b_min ? i_b_key : i_a_key;
        o_res.b_min    = w_b_min;
        o_res.child_lt = w_min < i_x_key;
        o_res.x_lt_a   = i_x_key < i_a_key;
    end

endmodule

// File: hw/rtl/bmh_ctrl.sv
module bmh_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic [bmh_pkg::KEY_BITS-1:0] i_key,
    input  logic [bmh_pkg::TAG_BITS-1:0] i_tag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bmh_pkg::KEY_BITS-1:0] o_out_key,
    output logic [bmh_pkg::TAG_BITS-1:0] o_out_tag,
    output logic [2:0]                   o_status,
    output logic [bmh_pkg::CW-1:0]       o_fill_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bmh_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_we,
    output logic [bmh_pkg::AW-1:0]       o_waddr,
    output bmh_pkg::t_entry              o_wdata,
    output logic [bmh_pkg::AW-1:0]       o_raddr_a,
    output logic [bmh_pkg::AW-1:0]       o_raddr_b,
    input  bmh_pkg::t_entry              i_rdata_a,
    input  bmh_pkg::t_entry              i_rdata_b,
    output logic [bmh_pkg::KEY_BITS-1:0] o_cmp_x,
    output logic                         o_cmp_b_ok,
    input  bmh_pkg::t_cmp                i_cmp
);

    import bmh_pkg::*;

    t_state              r_state, n_state;
    t_entry              r_x, n_x;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CFG_W-1:0]    r_cap;
    logic [KEY_BITS-1:0] r_okey, n_okey;
    logic [TAG_BITS-1:0] r_otag, n_otag;
    t_status             r_status, n_status;

    logic [CW-1:0] w_lim;
    logic          w_acc;
    logic          w_room;
    logic [AW-1:0] w_parent;
    logic [CW:0]   w_lc;
    logic [CW:0]   w_rc;
    logic          w_lc_in;
    logic          w_rc_in;

    always_comb begin
        if (r_cap == '0) begin
            w_lim = CW'(1);
        end else if (int'(r_cap) > DEPTH) begin
            w_lim = CW'(DEPTH);
        end else begin
            w_lim = CW'(r_cap);
        end
    end

    assign w_acc    = i_in_valid && o_in_ready;
    assign w_room   = r_cnt < w_lim;
    assign w_parent = (r_pos - AW'(1)) >> 1;
    assign w_lc     = (CW + 1)'({r_pos, 1'b1});
    assign w_rc     = w_lc + (CW + 1)'(1);
    assign w_lc_in  = w_lc < {1'b0, r_cnt};
    assign w_rc_in  = w_rc < {1'b0, r_cnt};

    assign o_cmp_x    = r_x.key;
    assign o_cmp_b_ok = (r_state == S_DN_CHK) && w_rc_in;

    assign o_cfg_ready  = 1'b1;
    assign o_out_key    = r_okey;
    assign o_out_tag    = r_otag;
    assign o_status     = r_status;
    assign o_fill_count = r_cnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_op == OP_INSERT) begin
                        n_state = w_room ? S_UP_RD : S_ROOT_CHK;
                    end else begin
                        n_state = (r_cnt == '0) ? S_DONE : S_POP_CHK;
                    end
                end
            end
            S_ROOT_CHK: n_state = i_cmp.child_lt ? S_DN_RD : S_DONE;
            S_POP_CHK:  n_state = S_DN_RD;
            S_UP_RD:    n_state = (r_pos == '0) ? S_DONE : S_UP_CHK;
            S_UP_CHK:   n_state = i_cmp.x_lt_a ? S_UP_RD : S_DONE;
            S_DN_RD:    n_state = w_lc_in ? S_DN_CHK : S_DONE;
            S_DN_CHK:   n_state = i_cmp.child_lt ? S_DN_RD : S_DONE;
            S_DONE:     n_state = i_out_ready ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_pos;
        o_wdata     = r_x;
        o_raddr_a   = '0;
        o_raddr_b   = '0;
        n_x         = r_x;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_okey      = r_okey;
        n_otag      = r_otag;
        n_status    = r_status;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_acc) begin
                    n_okey = '0;
                    n_otag = '0;
                    if (i_op == OP_INSERT) begin
                        n_x.key = i_key;
                        n_x.tag = i_tag;
                        if (w_room) begin
                            n_pos    = r_cnt[AW-1:0];
                            n_cnt    = r_cnt + CW'(1);
                            n_status = ST_INSERTED;
                        end
                    end else if (r_cnt == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        o_raddr_b = AW'(r_cnt - CW'(1));
                    end
                end
            end
            S_ROOT_CHK: begin
                n_pos    = '0;
                n_status = i_cmp.child_lt ? ST_REPLACED : ST_DROPPED;
            end
            S_POP_CHK: begin
                n_okey   = i_rdata_a.key;
                n_otag   = i_rdata_a.tag;
                n_x      = i_rdata_b;
                n_cnt    = r_cnt - CW'(1);
                n_pos    = '0;
                n_status = ST_POPPED;
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    o_we = 1'b1;
                end else begin
                    o_raddr_a = w_parent;
                end
            end
            S_UP_CHK: begin
                o_we = 1'b1;
                if (i_cmp.x_lt_a) begin
                    o_wdata = i_rdata_a;
                    n_pos   = w_parent;
                end
            end
            S_DN_RD: begin
                if (w_lc_in) begin
                    o_raddr_a = w_lc[AW-1:0];
                    o_raddr_b = w_rc[AW-1:0];
                end else begin
                    o_we = 1'b1;
                end
            end
            S_DN_CHK: begin
                o_we = 1'b1;
                if (i_cmp.child_lt) begin
                    o_wdata = i_cmp.b_min ? i_rdata_b : i_rdata_a;
                    n_pos   = i_cmp.b_min ? w_rc[AW-1:0] : w_lc[AW-1:0];
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cap   <= CFG_W'(CAP_RESET);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_pos    <= n_pos;
        r_okey   <= n_okey;
        r_otag   <= n_otag;
        r_status <= n_status;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_op == OP_POP && r_cnt == '0) |=>
        (o_out_valid && r_status == ST_EMPTY && r_cnt == '0))
        else $error("pop on empty heap not reported");

    a_wr_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> ((CW'(o_waddr) < r_cnt) || (r_cnt == '0)))
        else $error("write beyond held entries");

    a_ins_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == ST_INSERTED) |-> (r_cnt != '0))
        else $error("insert left heap empty");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("accepting while result pending");

endmodule

// File: hw/rtl/bounded_min_heap_top_k.sv
// Insert with room: the new entry is written at the next free slot and sifted up level by level.
// Replace or pop: the entry at the root is sifted down level by level; drop and empty pop need no walk.
// Each level takes one read state and one compare-and-write state on the shared heap memory.
// One transaction in flight: the next is accepted in the cycle after the result is taken.
// Synchronous active-low reset empties the heap and sets capacity to 256; memory is not cleared.
module bounded_min_heap_top_k (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic [bmh_pkg::KEY_BITS-1:0] i_key,
    input  logic [bmh_pkg::TAG_BITS-1:0] i_tag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bmh_pkg::KEY_BITS-1:0] o_out_key,
    output logic [bmh_pkg::TAG_BITS-1:0] o_out_tag,
    output logic [2:0]                   o_status,
    output logic [bmh_pkg::CW-1:0]       o_fill_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bmh_pkg::CFG_W-1:0]    i_cfg_data
);

    import bmh_pkg::*;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic [AW-1:0]       w_raddr_a;
    logic [AW-1:0]       w_raddr_b;
    t_entry              w_rdata_a;
    t_entry              w_rdata_b;
    logic [KEY_BITS-1:0] w_cmp_x;
    logic                w_cmp_b_ok;
    t_cmp                w_cmp;

    bmh_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    bmh_cmp u_cmp (
        .i_x_key (w_cmp_x),
        .i_a_key (w_rdata_a.key),
        .i_b_key (w_rdata_b.key),
        .i_b_ok  (w_cmp_b_ok),
        .o_res   (w_cmp)
    );

    bmh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_tag        (i_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_key    (o_out_key),
        .o_out_tag    (o_out_tag),
        .o_status     (o_status),
        .o_fill_count (o_fill_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr_a    (w_raddr_a),
        .o_raddr_b    (w_raddr_b),
        .i_rdata_a    (w_rdata_a),
        .i_rdata_b    (w_rdata_b),
        .o_cmp_x      (w_cmp_x),
        .o_cmp_b_ok   (w_cmp_b_ok),
        .i_cmp        (w_cmp)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bmh_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic                op;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_heap_req;

    typedef struct {
        logic [KEY_BITS-1:0] out_key;
        logic [TAG_BITS-1:0] out_tag;
        t_status             status;
        logic [CW-1:0]       fill;
    } t_heap_result;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_op = OP_INSERT;
    logic [KEY_BITS-1:0] in_key = '0;
    logic [TAG_BITS-1:0] in_tag = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [KEY_BITS-1:0] o_out_key;
    logic [TAG_BITS-1:0] o_out_tag;
    logic [2:0]          o_status;
    logic [CW-1:0]       o_fill_count;
    logic                o_cfg_ready;

    t_heap_req    pending_reqs[$];
    t_heap_result expected_results[$];

    logic [KEY_BITS-1:0] heap_key[DEPTH];
    logic [TAG_BITS-1:0] heap_tag[DEPTH];
    int                  heap_fill = 0;
    int                  cap_setting = CAP_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;
    int phase_count = 0;

    bounded_min_heap_top_k dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (in_op),
        .i_key        (in_key),
        .i_tag        (in_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_key    (o_out_key),
        .o_out_tag    (o_out_tag),
        .o_status     (o_status),
        .o_fill_count (o_fill_count),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic void swap_entries(int a, int b);
        logic [KEY_BITS-1:0] k;
        logic [TAG_BITS-1:0] t;
        k = heap_key[a];
        t = heap_tag[a];
        heap_key[a] = heap_key[b];
        heap_tag[a] = heap_tag[b];
        heap_key[b] = k;
        heap_tag[b] = t;
    endfunction

    function automatic void sift_down_from_root();
        int pos;
        int lc;
        int mc;
        pos = 0;
        forever begin
            lc = 2 * pos + 1;
            if (lc >= heap_fill) break;
            mc = lc;
            if (lc + 1 < heap_fill && heap_key[lc + 1] < heap_key[lc]) mc = lc + 1;
            if (!(heap_key[mc] < heap_key[pos])) break;
            swap_entries(mc, pos);
            pos = mc;
        end
    endfunction

    function automatic t_heap_result apply_heap_op(logic op, logic [KEY_BITS-1:0] key,
                                                   logic [TAG_BITS-1:0] tag);
        t_heap_result r;
        int limit;
        int pos;
        int up;
        r.out_key = '0;
        r.out_tag = '0;
        limit = (cap_setting == 0) ? 1 : (cap_setting > DEPTH) ? DEPTH : cap_setting;
        if (op == OP_INSERT) begin
            if (heap_fill < limit) begin
                heap_key[heap_fill] = key;
                heap_tag[heap_fill] = tag;
                pos = heap_fill;
                heap_fill++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (!(heap_key[pos] < heap_key[up])) break;
                    swap_entries(pos, up);
                    pos = up;
                end
                r.status = ST_INSERTED;
            end else if (heap_key[0] < key) begin
                heap_key[0] = key;
                heap_tag[0] = tag;
                sift_down_from_root();
                r.status = ST_REPLACED;
            end else begin
                r.status = ST_DROPPED;
            end
        end else if (heap_fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.out_key = heap_key[0];
            r.out_tag = heap_tag[0];
            heap_key[0] = heap_key[heap_fill - 1];
            heap_tag[0] = heap_tag[heap_fill - 1];
            heap_fill--;
            sift_down_from_root();
            r.status = ST_POPPED;
        end
        r.fill = heap_fill[CW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk) begin : drive_proc
        t_heap_req req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(apply_heap_op(in_op, in_key, in_tag));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = pending_reqs.pop_front();
                    in_op <= req.op;
                    in_key <= req.key;
                    in_tag <= req.tag;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : collect_proc
        t_heap_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_key !== want.out_key)
                        report_mismatch($sformatf("out_key %h, want %h", o_out_key, want.out_key));
                    if (o_out_tag !== want.out_tag)
                        report_mismatch($sformatf("out_tag %h, want %h", o_out_tag, want.out_tag));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_fill_count !== want.fill)
                        report_mismatch($sformatf("fill_count %0d, want %0d",
                                                  o_fill_count, want.fill));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : watchdog_proc
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[bounded_min_heap_top_k] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void push_req(logic op, logic [KEY_BITS-1:0] key,
                                     logic [TAG_BITS-1:0] tag);
        t_heap_req req;
        req.op = op;
        req.key = key;
        req.tag = tag;
        pending_reqs.push_back(req);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_BITS'($urandom_range(0, 15));
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    task automatic drain_heap_ops();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cap_setting = value;
    endtask

    task automatic start_phase();
        @(negedge clk);
        case (phase_count % 3)
            0: begin
                send_idle_pct = 22;
                recv_idle_pct = 85;
            end
            1: begin
                send_idle_pct = 85;
                recv_idle_pct = 22;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        phase_count++;
    endtask

    initial begin : sequence_proc
        int caps[9]     = '{511, 1, 256, 3, 2, 0, 255, 9, 256};
        int lengths[9]  = '{150, 120, 380, 120, 150, 150, 200, 100, 80};
        int ins_pcts[9] = '{75, 60, 92, 70, 20, 35, 55, 50, 10};
        int cap_value;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        start_phase();
        push_req(OP_POP, '0, '0);
        push_req(OP_INSERT, '1, '1);
        push_req(OP_INSERT, '0, '0);
        push_req(OP_INSERT, '0, 16'h1234);
        push_req(OP_INSERT, 32'd7, 16'h00ff);
        repeat (5) push_req(OP_POP, '1, '1);
        drain_heap_ops();

        write_capacity(9'd0);
        start_phase();
        push_req(OP_INSERT, 32'd5, 16'h000a);
        push_req(OP_INSERT, 32'd9, 16'h000b);
        push_req(OP_INSERT, 32'd3, 16'h000c);
        push_req(OP_INSERT, 32'd9, 16'h000d);
        push_req(OP_POP, '0, '0);
        push_req(OP_POP, '0, '0);
        push_req(OP_INSERT, '1, 16'h8001);
        push_req(OP_INSERT, '0, 16'h8002);
        drain_heap_ops();

        write_capacity(9'd2);
        start_phase();
        push_req(OP_INSERT, 32'd10, 16'h0010);
        push_req(OP_INSERT, 32'd20, 16'h0020);
        push_req(OP_INSERT, 32'd30, 16'h0030);
        push_req(OP_INSERT, 32'd5, 16'h0005);
        drain_heap_ops();

        for (int p = 0; p < 9; p++) begin
            cap_value = (caps[p] == 0) ? $urandom_range(4, 40) : caps[p];
            write_capacity(CFG_W'(cap_value));
            start_phase();
            for (int n = 0; n < lengths[p]; n++) begin
                if ($urandom_range(0, 99) < ins_pcts[p])
                    push_req(OP_INSERT, pick_key(), TAG_BITS'($urandom_range(0, 16'hffff)));
                else
                    push_req(OP_POP, KEY_BITS'($urandom), TAG_BITS'($urandom_range(0, 16'hffff)));
            end
            drain_heap_ops();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[bounded_min_heap_top_k] OK");
        end else begin
            $display("[bounded_min_heap_top_k] ERROR");
        end
        $finish;
    end

endmodule
